// ----- hdl/tdet_pkg.sv -----
// shared constants, codes and types of the time-of-day event table
`timescale 1ns / 1ps

package tdet_pkg;

  // table shape
  localparam int TABLE_DEPTH = 16;
  localparam int DUR_WORDS   = 4;
  localparam int IO_WORDS    = 4;
  localparam int COPY_WORDS  = (IO_WORDS < DUR_WORDS) ? IO_WORDS : DUR_WORDS;

  // field widths
  localparam int TIME_W  = 16;
  localparam int WORD_W  = 16;
  localparam int MODE_W  = 2;
  localparam int START_W = 4;

  // index into the table and entry count (count can hold the depth itself)
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // front-to-back queue, depth is a power of two so pointers wrap naturally
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // mode codes on the input channel
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

  // classified operation
  typedef enum logic [1:0] {
    OP_NOP,
    OP_ADD,
    OP_START,
    OP_TICK
  } op_e;

  // queued item
  typedef struct packed {
    op_e                             op;
    logic [TIME_W-1:0]               time_value;
    logic [IO_WORDS-1:0][WORD_W-1:0] dur;
  } item_t;

  // one table row
  typedef struct packed {
    logic                             active;
    logic [TIME_W-1:0]                time_value;
    logic [DUR_WORDS-1:0][WORD_W-1:0] dur;
  } row_t;

  // one result beat
  typedef struct packed {
    logic                            fired;
    logic [START_W-1:0]              start_index;
    logic [IO_WORDS-1:0][WORD_W-1:0] dur;
  } result_t;

endpackage

// ----- hdl/tdet_front.sv -----
// input front end: mode decode and a short item queue toward the back end
`timescale 1ns / 1ps

module tdet_front (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               in_valid_i,
  output logic                                               in_ready_o,
  input  logic [tdet_pkg::MODE_W-1:0]                        mode_i,
  input  logic [tdet_pkg::TIME_W-1:0]                        time_value_i,
  input  logic [tdet_pkg::IO_WORDS-1:0][tdet_pkg::WORD_W-1:0] dur_i,
  output logic                                               q_valid_o,
  output tdet_pkg::item_t                                    q_item_o,
  input  logic                                               q_pop_i
);

  tdet_pkg::item_t                    slots_q [tdet_pkg::QUEUE_DEPTH];
  tdet_pkg::item_t                    new_item;
  logic [tdet_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [tdet_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [tdet_pkg::QFILL_W-1:0]       fill_q, fill_d;
  logic                               push;
  logic                               pop;

  // classify the incoming beat
  always_comb begin
    new_item.time_value = time_value_i;
    new_item.dur        = dur_i;
    case (mode_i)
      tdet_pkg::MODE_ADD:   new_item.op = tdet_pkg::OP_ADD;
      tdet_pkg::MODE_START: new_item.op = tdet_pkg::OP_START;
      tdet_pkg::MODE_TICK:  new_item.op = tdet_pkg::OP_TICK;
      default:              new_item.op = tdet_pkg::OP_NOP;
    endcase
  end

  // queue handshakes
  assign in_ready_o = (fill_q != tdet_pkg::QFILL_W'(tdet_pkg::QUEUE_DEPTH));
  assign q_valid_o  = (fill_q != '0);
  assign q_item_o   = slots_q[rd_ptr_q];
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_pop_i & q_valid_o;

  // pointer and fill update
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + tdet_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + tdet_pkg::QPTR_W'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + tdet_pkg::QFILL_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - tdet_pkg::QFILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// ----- hdl/tdet_back.sv -----
// back end: table memory, exchange sort, locate scan, tick firing and result register
`timescale 1ns / 1ps

module tdet_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  tdet_pkg::item_t     q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tdet_pkg::result_t   result_o
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SORT_LDI = 7'b0000010,
    S_SORT_CMP = 7'b0000100,
    S_SORT_WRI = 7'b0001000,
    S_LOC_CMP  = 7'b0010000,
    S_TICK_CHK = 7'b0100000,
    S_TICK_CLR = 7'b1000000
  } state_e;

  state_e                        state_q, state_d;
  tdet_pkg::item_t               item_q, item_d;
  tdet_pkg::row_t                hold_q, hold_d;
  tdet_pkg::row_t                rd_q;
  tdet_pkg::result_t             res_q, res_d;
  logic [tdet_pkg::CNT_W-1:0]    count_q, count_d;
  logic [tdet_pkg::CNT_W-1:0]    i_q, i_d;
  logic [tdet_pkg::CNT_W-1:0]    j_q, j_d;
  logic [tdet_pkg::CNT_W-1:0]    i_inc, j_inc, cur_inc;
  logic [tdet_pkg::CNT_W-1:0]    loc_idx, loc_final;
  logic [tdet_pkg::IDX_W-1:0]    cur_q, cur_d;
  logic [tdet_pkg::IDX_W-1:0]    last_q, last_d;
  logic [tdet_pkg::IDX_W-1:0]    clr_q, clr_d;
  logic                          last_vld_q, last_vld_d;
  logic                          out_valid_q, out_valid_d;
  logic                          res_load;
  logic                          loc_done;

  // table memory, one row per entry
  tdet_pkg::row_t                mem [tdet_pkg::TABLE_DEPTH];
  logic                          mem_we;
  logic [tdet_pkg::IDX_W-1:0]    mem_waddr;
  tdet_pkg::row_t                mem_wdata;
  logic [tdet_pkg::IDX_W-1:0]    rd_addr;
  tdet_pkg::row_t                add_row;

  assign i_inc   = i_q + tdet_pkg::CNT_W'(1);
  assign j_inc   = j_q + tdet_pkg::CNT_W'(1);
  assign cur_inc = tdet_pkg::CNT_W'(cur_q) + tdet_pkg::CNT_W'(1);

  // final located index: the one before the first later entry, wrapping to 0
  assign loc_final = ((loc_idx == '0) || (loc_idx == count_q)) ?
                     '0 : loc_idx - tdet_pkg::CNT_W'(1);

  // row written by an add
  always_comb begin
    add_row.active     = 1'b0;
    add_row.time_value = q_item_i.time_value;
    add_row.dur        = '0;
    for (int w = 0; w < tdet_pkg::COPY_WORDS; w++) begin
      add_row.dur[w] = q_item_i.dur[w];
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    hold_d      = hold_q;
    count_d     = count_q;
    i_d         = i_q;
    j_d         = j_q;
    cur_d       = cur_q;
    last_d      = last_q;
    last_vld_d  = last_vld_q;
    clr_d       = clr_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = hold_q;
    rd_addr     = '0;
    q_pop_o     = 1'b0;
    res_load    = 1'b0;
    res_d       = '0;
    loc_done    = 1'b0;
    loc_idx     = j_q;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          case (q_item_i.op)
            tdet_pkg::OP_ADD: begin
              if (count_q < tdet_pkg::CNT_W'(tdet_pkg::TABLE_DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = count_q[tdet_pkg::IDX_W-1:0];
                mem_wdata = add_row;
                count_d   = count_q + tdet_pkg::CNT_W'(1);
              end
              res_load = 1'b1;
            end
            tdet_pkg::OP_START: begin
              last_vld_d = 1'b0;
              if (count_q == '0) begin
                cur_d    = '0;
                res_load = 1'b1;
              end else begin
                i_d     = '0;
                rd_addr = '0;
                state_d = S_SORT_LDI;
              end
            end
            tdet_pkg::OP_TICK: begin
              if (tdet_pkg::CNT_W'(cur_q) < count_q) begin
                rd_addr = cur_q;
                state_d = S_TICK_CHK;
              end else begin
                res_load = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      // hold row i, then sweep j over the rest
      S_SORT_LDI: begin
        hold_d = rd_q;
        if (i_inc >= count_q) begin
          j_d     = '0;
          rd_addr = '0;
          state_d = S_LOC_CMP;
        end else begin
          j_d     = i_inc;
          rd_addr = i_inc[tdet_pkg::IDX_W-1:0];
          state_d = S_SORT_CMP;
        end
      end

      // exchange held row with row j when j is earlier
      S_SORT_CMP: begin
        if (hold_q.time_value > rd_q.time_value) begin
          mem_we    = 1'b1;
          mem_waddr = j_q[tdet_pkg::IDX_W-1:0];
          mem_wdata = hold_q;
          hold_d    = rd_q;
        end
        j_d = j_inc;
        if (j_inc < count_q) begin
          rd_addr = j_inc[tdet_pkg::IDX_W-1:0];
        end else begin
          state_d = S_SORT_WRI;
        end
      end

      // write back row i and fetch row i + 1
      S_SORT_WRI: begin
        mem_we    = 1'b1;
        mem_waddr = i_q[tdet_pkg::IDX_W-1:0];
        mem_wdata = hold_q;
        i_d       = i_inc;
        rd_addr   = i_inc[tdet_pkg::IDX_W-1:0];
        state_d   = S_SORT_LDI;
      end

      // count entries at or before now
      S_LOC_CMP: begin
        if (rd_q.time_value <= item_q.time_value) begin
          if (j_inc < count_q) begin
            j_d     = j_inc;
            rd_addr = j_inc[tdet_pkg::IDX_W-1:0];
          end else begin
            loc_idx  = count_q;
            loc_done = 1'b1;
          end
        end else begin
          loc_idx  = j_q;
          loc_done = 1'b1;
        end
        if (loc_done) begin
          cur_d             = loc_final[tdet_pkg::IDX_W-1:0];
          res_d.start_index = tdet_pkg::START_W'(loc_final);
          res_load          = 1'b1;
          state_d           = S_IDLE;
        end
      end

      // fire the current entry when due and not active
      S_TICK_CHK: begin
        res_load = 1'b1;
        state_d  = S_IDLE;
        if (!rd_q.active && (rd_q.time_value == item_q.time_value)) begin
          mem_we           = 1'b1;
          mem_waddr        = cur_q;
          mem_wdata        = rd_q;
          mem_wdata.active = 1'b1;
          res_d.fired      = 1'b1;
          for (int w = 0; w < tdet_pkg::COPY_WORDS; w++) begin
            res_d.dur[w] = rd_q.dur[w];
          end
          cur_d      = (cur_inc >= count_q) ? '0 : cur_inc[tdet_pkg::IDX_W-1:0];
          last_d     = cur_q;
          last_vld_d = 1'b1;
          clr_d      = last_q;
          if (last_vld_q) begin
            rd_addr = last_q;
            state_d = S_TICK_CLR;
          end
        end
      end

      // drop the active flag of the previously fired entry
      S_TICK_CLR: begin
        mem_we           = 1'b1;
        mem_waddr        = clr_q;
        mem_wdata        = rd_q;
        mem_wdata.active = 1'b0;
        state_d          = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      cur_q       <= '0;
      last_q      <= '0;
      last_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      i_q         <= i_d;
      j_q         <= j_d;
      cur_q       <= cur_d;
      last_q      <= last_d;
      last_vld_q  <= last_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    hold_q <= hold_d;
    clr_q  <= clr_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // memory write port and registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rd_addr];
  end

endmodule

// ----- hdl/time_of_day_event_table.sv -----
// Time-of-day event table, top level.
//
// Input channel (in_valid_i / in_ready_o) takes one beat per item: mode_i picks
// add entry, start (sort by time and locate) or tick at time_value_i. Output
// channel (out_valid_o / out_ready_i) gives exactly one beat per item: fired_o,
// start_index_o and the four duration words of a fired entry, zero otherwise.
// Items go through a two-deep queue into the back end, which works one item
// at a time against a table memory with one write and one registered read port.
// An add, an ignored item, a start on an empty table and a tick with no entry
// to look at load the result straight from idle; other ticks first read the
// pointed-at entry. A start on a non-empty table runs the exchange sort over
// the stored entries, then the locate scan. A tick that also clears an older
// flag passes through an extra clear state. The next item leaves the queue
// once the back end is idle and the previous result beat has been taken;
// while the receiver stalls the result holds, the queue fills, and then
// in_ready_o drops.
// Reset empties the table, sets the pointer to entry 0 and forgets the last
// fired entry; no memory clearing pass is needed.
`timescale 1ns / 1ps

module time_of_day_event_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tdet_pkg::MODE_W-1:0]   mode_i,
  input  logic [tdet_pkg::TIME_W-1:0]   time_value_i,
  input  logic [tdet_pkg::WORD_W-1:0]   dur_0_i,
  input  logic [tdet_pkg::WORD_W-1:0]   dur_1_i,
  input  logic [tdet_pkg::WORD_W-1:0]   dur_2_i,
  input  logic [tdet_pkg::WORD_W-1:0]   dur_3_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          fired_o,
  output logic [tdet_pkg::START_W-1:0]  start_index_o,
  output logic [tdet_pkg::WORD_W-1:0]   out_dur_0_o,
  output logic [tdet_pkg::WORD_W-1:0]   out_dur_1_o,
  output logic [tdet_pkg::WORD_W-1:0]   out_dur_2_o,
  output logic [tdet_pkg::WORD_W-1:0]   out_dur_3_o
);

  logic [tdet_pkg::IO_WORDS-1:0][tdet_pkg::WORD_W-1:0] in_dur;
  logic                                                q_valid;
  logic                                                q_pop;
  tdet_pkg::item_t                                     q_item;
  tdet_pkg::result_t                                   result;

  // gather duration words of the input beat
  assign in_dur[0] = dur_0_i;
  assign in_dur[1] = dur_1_i;
  assign in_dur[2] = dur_2_i;
  assign in_dur[3] = dur_3_i;

  // decode and queue
  tdet_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .time_value_i (time_value_i),
    .dur_i        (in_dur),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  // table operations
  tdet_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  // result beat fields
  assign fired_o       = result.fired;
  assign start_index_o = result.start_index;
  assign out_dur_0_o   = result.dur[0];
  assign out_dur_1_o   = result.dur[1];
  assign out_dur_2_o   = result.dur[2];
  assign out_dur_3_o   = result.dur[3];

endmodule

// ----- sim/time_of_day_event_table_test.sv -----
// self-checking testbench for the time-of-day event table
`timescale 1ns / 1ps

module time_of_day_event_table_test;

  localparam logic [tdet_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1020;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 300;
  localparam int CALM_FROM    = 600;
  localparam int CALM_TO      = 750;
  localparam int DRAIN_CYCLES = 200;
  localparam int PRINT_CAP    = 100;

  typedef logic [tdet_pkg::IO_WORDS-1:0][tdet_pkg::WORD_W-1:0] words_t;

  // table shadow and the queue of results still owed by the block
  class event_table_board;
    tdet_pkg::row_t    rows[tdet_pkg::TABLE_DEPTH];
    int unsigned       stored;
    int unsigned       next_slot;
    int unsigned       prev_fired;
    bit                prev_fired_ok;
    tdet_pkg::result_t owed_results[$];
    int unsigned       mismatches;

    function new();
      foreach (rows[i]) rows[i] = '0;
      stored        = 0;
      next_slot     = 0;
      prev_fired    = 0;
      prev_fired_ok = 1'b0;
      mismatches    = 0;
    endfunction

    function logic [tdet_pkg::TIME_W-1:0] time_at(int unsigned i);
      return rows[i].time_value;
    endfunction

    // time the pointed-at entry waits for
    function logic [tdet_pkg::TIME_W-1:0] next_due_time();
      if (stored == 0) return '0;
      return rows[next_slot].time_value;
    endfunction

    // exchange sort over the stored rows, flags travel with their rows
    function void sort_rows();
      tdet_pkg::row_t tmp;
      for (int i = 0; i < stored; i++) begin
        for (int j = i + 1; j < stored; j++) begin
          if (rows[i].time_value > rows[j].time_value) begin
            tmp     = rows[i];
            rows[i] = rows[j];
            rows[j] = tmp;
          end
        end
      end
    endfunction

    // work out the result of one accepted beat and queue it
    function void note_item(logic [tdet_pkg::MODE_W-1:0] mode,
                            logic [tdet_pkg::TIME_W-1:0] tv, words_t words);
      tdet_pkg::result_t res;
      int unsigned       pos;
      int unsigned       look;
      res = '0;
      case (mode)
        tdet_pkg::MODE_ADD: begin
          if (stored < tdet_pkg::TABLE_DEPTH) begin
            rows[stored].active     = 1'b0;
            rows[stored].time_value = tv;
            for (int w = 0; w < tdet_pkg::DUR_WORDS; w++) begin
              rows[stored].dur[w] = (w < tdet_pkg::IO_WORDS) ? words[w] : '0;
            end
            stored++;
          end
        end
        tdet_pkg::MODE_START: begin
          prev_fired_ok = 1'b0;
          prev_fired    = 0;
          sort_rows();
          pos = 0;
          while (pos < stored && rows[pos].time_value <= tv) pos++;
          // past the end the look goes back to entry 0
          if (pos > 0) begin
            look = (pos >= stored) ? 0 : pos;
            if (rows[look].time_value > tv) pos--;
          end
          if (pos >= stored) pos = 0;
          next_slot       = pos;
          res.start_index = tdet_pkg::START_W'(pos);
        end
        tdet_pkg::MODE_TICK: begin
          if (next_slot < stored && !rows[next_slot].active &&
              rows[next_slot].time_value == tv) begin
            rows[next_slot].active = 1'b1;
            if (prev_fired_ok && prev_fired < tdet_pkg::TABLE_DEPTH)
              rows[prev_fired].active = 1'b0;
            res.fired = 1'b1;
            for (int w = 0; w < tdet_pkg::IO_WORDS; w++) begin
              res.dur[w] = (w < tdet_pkg::DUR_WORDS) ? rows[next_slot].dur[w] : '0;
            end
            prev_fired    = next_slot;
            prev_fired_ok = 1'b1;
            next_slot     = (next_slot + 1 >= stored) ? 0 : next_slot + 1;
          end
        end
        default: ;
      endcase
      owed_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t: mismatch, %s", $time, what);
    endtask

    // compare one result beat with the oldest owed result
    task check_result(tdet_pkg::result_t got);
      tdet_pkg::result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch("result beat with nothing owed");
        return;
      end
      want = owed_results.pop_front();
      if (got.fired !== want.fired)
        report_mismatch($sformatf("fired got %0b expected %0b", got.fired, want.fired));
      if (got.start_index !== want.start_index)
        report_mismatch($sformatf("start_index got %0d expected %0d",
                                  got.start_index, want.start_index));
      for (int w = 0; w < tdet_pkg::IO_WORDS; w++) begin
        if (got.dur[w] !== want.dur[w])
          report_mismatch($sformatf("out_dur_%0d got %h expected %h", w, got.dur[w],
                                    want.dur[w]));
      end
    endtask
  endclass

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_ready_o;
  logic [tdet_pkg::MODE_W-1:0]   mode_i        = tdet_pkg::MODE_ADD;
  logic [tdet_pkg::TIME_W-1:0]   time_value_i  = '0;
  logic [tdet_pkg::WORD_W-1:0]   dur_0_i       = '0;
  logic [tdet_pkg::WORD_W-1:0]   dur_1_i       = '0;
  logic [tdet_pkg::WORD_W-1:0]   dur_2_i       = '0;
  logic [tdet_pkg::WORD_W-1:0]   dur_3_i       = '0;
  logic                          out_valid_o;
  logic                          out_ready_i   = 1'b0;
  logic                          fired_o;
  logic [tdet_pkg::START_W-1:0]  start_index_o;
  logic [tdet_pkg::WORD_W-1:0]   out_dur_0_o;
  logic [tdet_pkg::WORD_W-1:0]   out_dur_1_o;
  logic [tdet_pkg::WORD_W-1:0]   out_dur_2_o;
  logic [tdet_pkg::WORD_W-1:0]   out_dur_3_o;

  event_table_board board;
  bit               calm_phase   = 1'b0;
  bit               hold_request = 1'b0;
  bit               hold_issued  = 1'b0;
  int unsigned      cycle_count;

  time_of_day_event_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .time_value_i  (time_value_i),
    .dur_0_i       (dur_0_i),
    .dur_1_i       (dur_1_i),
    .dur_2_i       (dur_2_i),
    .dur_3_i       (dur_3_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .fired_o       (fired_o),
    .start_index_o (start_index_o),
    .out_dur_0_o   (out_dur_0_o),
    .out_dur_1_o   (out_dur_1_o),
    .out_dur_2_o   (out_dur_2_o),
    .out_dur_3_o   (out_dur_3_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // result side: check accepted beats, random stalls and one long hold-off
  initial begin
    tdet_pkg::result_t got;
    int unsigned       hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.fired       = fired_o;
        got.start_index = start_index_o;
        got.dur[0]      = out_dur_0_o;
        got.dur[1]      = out_dur_1_o;
        got.dur[2]      = out_dur_2_o;
        got.dur[3]      = out_dur_3_o;
        board.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm_phase || ($urandom_range(99) >= 33);
      end
    end
  end

  function automatic logic [tdet_pkg::WORD_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return tdet_pkg::WORD_W'($urandom);
  endfunction

  // offer one beat, wait for it to be taken, then log it with the board
  task automatic send_item(logic [tdet_pkg::MODE_W-1:0] mode,
                           logic [tdet_pkg::TIME_W-1:0] tv, words_t words);
    while (!calm_phase && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    time_value_i <= tv;
    dur_0_i      <= words[0];
    dur_1_i      <= words[1];
    dur_2_i      <= words[2];
    dur_3_i      <= words[3];
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(mode, tv, words);
  endtask

  // mostly ticks aimed at the pending entry and starts near stored times
  task automatic send_random_item(output bit counted);
    int unsigned                 roll;
    int unsigned                 n;
    int unsigned                 sel;
    logic [tdet_pkg::MODE_W-1:0] mode;
    logic [tdet_pkg::TIME_W-1:0] tv;
    logic [tdet_pkg::TIME_W-1:0] near;
    words_t                      words;
    n    = board.stored;
    roll = $urandom_range(99);
    sel  = $urandom_range(9);
    for (int w = 0; w < tdet_pkg::IO_WORDS; w++) words[w] = pick_word();
    near = (n == 0) ? tdet_pkg::TIME_W'($urandom) : board.time_at($urandom_range(n - 1));
    if (roll < 25 && n < tdet_pkg::TABLE_DEPTH) begin
      // a small pool of times gives plenty of duplicates
      mode = tdet_pkg::MODE_ADD;
      tv   = ($urandom_range(1) == 0) ? tdet_pkg::TIME_W'($urandom_range(7) * 9000) :
                                        tdet_pkg::TIME_W'($urandom);
    end else if (roll < 40) begin
      mode = tdet_pkg::MODE_START;
      case (sel)
        0, 1, 2, 3: tv = near;
        4:          tv = near - 1'b1;
        5:          tv = near + 1'b1;
        6:          tv = '0;
        7:          tv = '1;
        default:    tv = tdet_pkg::TIME_W'($urandom);
      endcase
    end else if (roll < 90) begin
      mode = tdet_pkg::MODE_TICK;
      case (sel)
        7:       tv = board.next_due_time() + 1'b1;
        8:       tv = tdet_pkg::TIME_W'($urandom);
        9:       tv = near;
        default: tv = board.next_due_time();
      endcase
    end else if (roll < 95) begin
      mode = MODE_UNUSED;
      tv   = tdet_pkg::TIME_W'($urandom);
    end else begin
      mode = tdet_pkg::MODE_ADD;
      tv   = tdet_pkg::TIME_W'($urandom);
    end
    counted = !(mode == MODE_UNUSED ||
                (mode == tdet_pkg::MODE_ADD && n >= tdet_pkg::TABLE_DEPTH));
    send_item(mode, tv, words);
  endtask

  // stimulus and verdict
  initial begin
    int unsigned done_items;
    bit          counted;
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, unused mode with all bits set
    send_item(tdet_pkg::MODE_TICK, 16'd0, '0);
    send_item(tdet_pkg::MODE_START, 16'd0, '0);
    send_item(MODE_UNUSED, 16'hffff, '1);
    // three entries out of order, extreme times and words
    send_item(tdet_pkg::MODE_ADD, 16'd100, '0);
    send_item(tdet_pkg::MODE_ADD, 16'hffff, '1);
    send_item(tdet_pkg::MODE_ADD, 16'd0, {16'd4, 16'd3, 16'd2, 16'd1});
    // locate between entries, then walk the table with ticks
    send_item(tdet_pkg::MODE_START, 16'd50, '0);
    send_item(tdet_pkg::MODE_TICK, 16'd0, '0);
    send_item(tdet_pkg::MODE_TICK, 16'd0, '0);
    send_item(tdet_pkg::MODE_TICK, 16'd100, '0);
    send_item(tdet_pkg::MODE_TICK, 16'hffff, '0);
    // locate past the end wraps to the first entry
    send_item(tdet_pkg::MODE_START, 16'hffff, '0);
    send_item(tdet_pkg::MODE_TICK, 16'd0, '0);
    send_item(tdet_pkg::MODE_START, 16'hfffe, '0);
    send_item(tdet_pkg::MODE_TICK, 16'd100, '0);
    // last entry still flagged from before the start, so no fire
    send_item(tdet_pkg::MODE_TICK, 16'hffff, '0);
    // duplicate time
    send_item(tdet_pkg::MODE_ADD, 16'd100, {16'h8000, 16'h7fff, 16'h5555, 16'haaaa});
    send_item(tdet_pkg::MODE_START, 16'd100, '0);
    send_item(tdet_pkg::MODE_TICK, 16'd100, '0);
    send_item(tdet_pkg::MODE_START, 16'd0, '0);

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      if (done_items == HOLD_AT && !hold_issued) begin
        hold_issued  = 1'b1;
        hold_request = 1'b1;
      end
      calm_phase = (done_items >= CALM_FROM && done_items < CALM_TO);
      send_random_item(counted);
      if (counted) done_items++;
    end
    in_valid_i <= 1'b0;

    while (board.owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- time_of_day_event_table.f -----
hdl/tdet_pkg.sv
hdl/tdet_front.sv
hdl/tdet_back.sv
hdl/time_of_day_event_table.sv
sim/time_of_day_event_table_test.sv
